// File: src/mit_motor_command_packer_assert.svh
// assertion macros shared by the command packer modules
`ifndef MIT_MOTOR_COMMAND_PACKER_ASSERT_SVH
`define MIT_MOTOR_COMMAND_PACKER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define MCP_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequence holds in the same cycle as the antecedent
`define MCP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define MCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/mcp_pkg.sv
// package of types and constants for the motor command packer
package mcp_pkg;

   localparam int REG_W         = 30;
   localparam int CSR_INDEX_W   = 3;
   localparam int SETPOINT_W    = 32;
   localparam int RANGE_W       = SETPOINT_W + 1;
   localparam int OFF_W         = 31;
   localparam int QUOT_W        = 16;
   localparam int POS_CODE_W    = 16;
   localparam int NARROW_CODE_W = 12;
   localparam int LANE_LATENCY  = QUOT_W + 2;
   localparam int LATENCY       = LANE_LATENCY + 1;

   localparam logic [REG_W-1:0] POSITION_LIMIT_RESET = REG_W'(819200);
   localparam logic [REG_W-1:0] VELOCITY_LIMIT_RESET = REG_W'(1966080);
   localparam logic [REG_W-1:0] TORQUE_LIMIT_RESET   = REG_W'(655360);
   localparam logic [REG_W-1:0] STIFFNESS_MIN_RESET  = REG_W'(0);
   localparam logic [REG_W-1:0] STIFFNESS_MAX_RESET  = REG_W'(32768000);
   localparam logic [REG_W-1:0] DAMPING_MIN_RESET    = REG_W'(0);
   localparam logic [REG_W-1:0] DAMPING_MAX_RESET    = REG_W'(327680);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POSITION_LIMIT = 3'd0,
      REG_VELOCITY_LIMIT = 3'd1,
      REG_TORQUE_LIMIT   = 3'd2,
      REG_STIFFNESS_MIN  = 3'd3,
      REG_STIFFNESS_MAX  = 3'd4,
      REG_DAMPING_MIN    = 3'd5,
      REG_DAMPING_MAX    = 3'd6
   } mcp_reg_index_type;

   typedef struct packed {
      logic signed [SETPOINT_W-1:0] target_position;
      logic signed [SETPOINT_W-1:0] target_velocity;
      logic signed [SETPOINT_W-1:0] stiffness_gain;
      logic signed [SETPOINT_W-1:0] damping_gain;
      logic signed [SETPOINT_W-1:0] feedforward_torque;
   } mcp_req_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [7:0] byte4;
      logic [7:0] byte5;
      logic [7:0] byte6;
      logic [7:0] byte7;
   } mcp_rsp_type;

   typedef struct packed {
      logic [POS_CODE_W-1:0]    position;
      logic [NARROW_CODE_W-1:0] velocity;
      logic [NARROW_CODE_W-1:0] stiffness;
      logic [NARROW_CODE_W-1:0] damping;
      logic [NARROW_CODE_W-1:0] torque;
   } mcp_codes_type;

endpackage

// File: src/mcp_lane.sv
// one scaling lane: clamp, numerator build and pipelined restoring divider
module mcp_lane #(
   parameter int CODE_BITS = mcp_pkg::NARROW_CODE_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_in,
   input  logic signed [mcp_pkg::SETPOINT_W-1:0] x,
   input  logic signed [mcp_pkg::RANGE_W-1:0]    lo,
   input  logic signed [mcp_pkg::RANGE_W-1:0]    hi,
   output logic                                valid_out,
   output logic [CODE_BITS-1:0]                code
);

   localparam int STEPS = mcp_pkg::QUOT_W;
   localparam int OFF_W = mcp_pkg::OFF_W;
   localparam int NUM_W = OFF_W + STEPS;

   // clamp stage
   logic signed [mcp_pkg::RANGE_W-1:0] xe;
   logic signed [mcp_pkg::RANGE_W-1:0] xc;
   logic signed [mcp_pkg::RANGE_W-1:0] off_full;
   logic signed [mcp_pkg::RANGE_W-1:0] span_full;
   logic                               empty;
   logic [OFF_W-1:0]                   off_in;
   logic [OFF_W-1:0]                   off_ff;
   logic [OFF_W-1:0]                   span_a_in;
   logic [OFF_W-1:0]                   span_a_ff;
   logic                               va_ff;

   always_comb begin
      xe        = {x[mcp_pkg::SETPOINT_W-1], x};
      empty     = (hi <= lo);
      if (xe < lo) begin
         xc = lo;
      end else if (xe > hi) begin
         xc = hi;
      end else begin
         xc = xe;
      end
      off_full  = xc - lo;
      span_full = hi - lo;
      // empty range gives a zero numerator over a span of one
      off_in    = empty ? '0 : off_full[OFF_W-1:0];
      span_a_in = empty ? OFF_W'(1) : span_full[OFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      off_ff    <= off_in;
      span_a_ff <= span_a_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= valid_in;
      end
   end

   // numerator stage: off * (2^bits - 1)
   logic [NUM_W-1:0] off_ext;
   logic [NUM_W-1:0] num_in;

   logic [OFF_W-1:0] r_ff    [0:STEPS];
   logic [STEPS-1:0] low_ff  [0:STEPS];
   logic [STEPS-1:0] q_ff    [0:STEPS];
   logic [OFF_W-1:0] span_ff [0:STEPS];
   logic             v_ff    [0:STEPS];

   always_comb begin
      off_ext = NUM_W'(off_ff);
      num_in  = (off_ext << CODE_BITS) - off_ext;
   end

   always_ff @(posedge clock) begin
      r_ff[0]    <= num_in[NUM_W-1:STEPS];
      low_ff[0]  <= num_in[STEPS-1:0];
      q_ff[0]    <= '0;
      span_ff[0] <= span_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= va_ff;
      end
   end

   // one quotient bit per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [OFF_W:0]   trial;
      logic [OFF_W:0]   diff;
      logic             ge;
      logic [OFF_W-1:0] r_in;

      always_comb begin
         trial = {r_ff[i], low_ff[i][STEPS-1]};
         diff  = trial - {1'b0, span_ff[i]};
         ge    = (trial >= {1'b0, span_ff[i]});
         r_in  = ge ? diff[OFF_W-1:0] : trial[OFF_W-1:0];
      end

      always_ff @(posedge clock) begin
         r_ff[i+1]    <= r_in;
         low_ff[i+1]  <= {low_ff[i][STEPS-2:0], 1'b0};
         q_ff[i+1]    <= {q_ff[i][STEPS-2:0], ge};
         span_ff[i+1] <= span_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end
   end

   assign valid_out = v_ff[STEPS];
   assign code      = q_ff[STEPS][CODE_BITS-1:0];

`include "mit_motor_command_packer_assert.svh"

   `MCP_ASSERT_IMPL(a_rem_below_span, valid_out, r_ff[STEPS] < span_ff[STEPS], "remainder not below span")
   `MCP_ASSERT_IMPL(a_code_fits, valid_out, (q_ff[STEPS] >> CODE_BITS) == '0, "quotient exceeds code width")

endmodule

// File: src/mcp_frame_pack.sv
// merge stage: packs the five lane codes into the eight byte frame
module mcp_frame_pack (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  mcp_pkg::mcp_codes_type codes,
   output logic                   rsp_strobe,
   output mcp_pkg::mcp_rsp_type   rsp_data
);

   mcp_pkg::mcp_rsp_type rsp_data_in;
   mcp_pkg::mcp_rsp_type rsp_data_ff;
   logic                 rsp_strobe_ff;

   always_comb begin
      rsp_data_in.byte0 = codes.position[15:8];
      rsp_data_in.byte1 = codes.position[7:0];
      rsp_data_in.byte2 = codes.velocity[11:4];
      rsp_data_in.byte3 = {codes.velocity[3:0], codes.stiffness[11:8]};
      rsp_data_in.byte4 = codes.stiffness[7:0];
      rsp_data_in.byte5 = codes.damping[11:4];
      rsp_data_in.byte6 = {codes.damping[3:0], codes.torque[11:8]};
      rsp_data_in.byte7 = codes.torque[7:0];
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`include "mit_motor_command_packer_assert.svh"

   `MCP_ASSERT_NEXT(a_strobe_follows, valid_in, rsp_strobe, "frame strobe lost")

endmodule

// File: src/mit_motor_command_packer.sv
// top level of the motor command packer
//
// Request channel: a set of five signed Q16.16 setpoints is transferred on
// req_data at a clock edge where req_start is high and busy is low. busy is
// high only while reset is asserted, so a new set may follow every cycle.
// Each setpoint goes through its own lane: clamp, numerator build and a
// sixteen stage restoring divider that retires one quotient bit per stage.
// A merge stage packs the codes into an eight byte frame.
// Response channel: rsp_strobe is high for one cycle with the frame on
// rsp_data once the transfer has passed the clamp, numerator, 16 divider
// and pack registers. Throughput is one frame per cycle, set by the fully
// pipelined divider stages. The receiver cannot stall the block.
// CSR port: csr_write_en writes csr_data into register csr_index at the
// clock edge; unknown indices are ignored. Write only while no request is
// in flight.
// Reset: synchronous; clears all in-flight transfers and loads the default
// range registers.
module mit_motor_command_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_start,
   output logic                                 busy,
   input  mcp_pkg::mcp_req_type                 req_data,
   output logic                                 rsp_strobe,
   output mcp_pkg::mcp_rsp_type                 rsp_data,
   input  logic                                 csr_write_en,
   input  logic [mcp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mcp_pkg::REG_W-1:0]            csr_data
);

   localparam int RW = mcp_pkg::RANGE_W;

   logic [mcp_pkg::REG_W-1:0] position_limit_ff;
   logic [mcp_pkg::REG_W-1:0] velocity_limit_ff;
   logic [mcp_pkg::REG_W-1:0] torque_limit_ff;
   logic [mcp_pkg::REG_W-1:0] stiffness_min_ff;
   logic [mcp_pkg::REG_W-1:0] stiffness_max_ff;
   logic [mcp_pkg::REG_W-1:0] damping_min_ff;
   logic [mcp_pkg::REG_W-1:0] damping_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_limit_ff <= mcp_pkg::POSITION_LIMIT_RESET;
         velocity_limit_ff <= mcp_pkg::VELOCITY_LIMIT_RESET;
         torque_limit_ff   <= mcp_pkg::TORQUE_LIMIT_RESET;
         stiffness_min_ff  <= mcp_pkg::STIFFNESS_MIN_RESET;
         stiffness_max_ff  <= mcp_pkg::STIFFNESS_MAX_RESET;
         damping_min_ff    <= mcp_pkg::DAMPING_MIN_RESET;
         damping_max_ff    <= mcp_pkg::DAMPING_MAX_RESET;
      end else if (csr_write_en) begin
         unique case (mcp_pkg::mcp_reg_index_type'(csr_index))
            mcp_pkg::REG_POSITION_LIMIT: position_limit_ff <= csr_data;
            mcp_pkg::REG_VELOCITY_LIMIT: velocity_limit_ff <= csr_data;
            mcp_pkg::REG_TORQUE_LIMIT:   torque_limit_ff   <= csr_data;
            mcp_pkg::REG_STIFFNESS_MIN:  stiffness_min_ff  <= csr_data;
            mcp_pkg::REG_STIFFNESS_MAX:  stiffness_max_ff  <= csr_data;
            mcp_pkg::REG_DAMPING_MIN:    damping_min_ff    <= csr_data;
            mcp_pkg::REG_DAMPING_MAX:    damping_max_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   logic accept;
   assign busy   = reset;
   assign accept = req_start && !busy;

   // lane ranges
   logic signed [RW-1:0] pos_hi;
   logic signed [RW-1:0] pos_lo;
   logic signed [RW-1:0] vel_hi;
   logic signed [RW-1:0] vel_lo;
   logic signed [RW-1:0] trq_hi;
   logic signed [RW-1:0] trq_lo;
   logic signed [RW-1:0] kp_hi;
   logic signed [RW-1:0] kp_lo;
   logic signed [RW-1:0] kd_hi;
   logic signed [RW-1:0] kd_lo;

   always_comb begin
      pos_hi = {3'b000, position_limit_ff};
      pos_lo = -pos_hi;
      vel_hi = {3'b000, velocity_limit_ff};
      vel_lo = -vel_hi;
      trq_hi = {3'b000, torque_limit_ff};
      trq_lo = -trq_hi;
      kp_hi  = {3'b000, stiffness_max_ff};
      kp_lo  = {3'b000, stiffness_min_ff};
      kd_hi  = {3'b000, damping_max_ff};
      kd_lo  = {3'b000, damping_min_ff};
   end

   logic                  pos_valid;
   logic                  vel_valid;
   logic                  kp_valid;
   logic                  kd_valid;
   logic                  trq_valid;
   mcp_pkg::mcp_codes_type codes;

   mcp_lane #(.CODE_BITS(mcp_pkg::POS_CODE_W)) u_pos_lane (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .x         (req_data.target_position),
      .lo        (pos_lo),
      .hi        (pos_hi),
      .valid_out (pos_valid),
      .code      (codes.position)
   );

   mcp_lane #(.CODE_BITS(mcp_pkg::NARROW_CODE_W)) u_vel_lane (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .x         (req_data.target_velocity),
      .lo        (vel_lo),
      .hi        (vel_hi),
      .valid_out (vel_valid),
      .code      (codes.velocity)
   );

   mcp_lane #(.CODE_BITS(mcp_pkg::NARROW_CODE_W)) u_kp_lane (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .x         (req_data.stiffness_gain),
      .lo        (kp_lo),
      .hi        (kp_hi),
      .valid_out (kp_valid),
      .code      (codes.stiffness)
   );

   mcp_lane #(.CODE_BITS(mcp_pkg::NARROW_CODE_W)) u_kd_lane (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .x         (req_data.damping_gain),
      .lo        (kd_lo),
      .hi        (kd_hi),
      .valid_out (kd_valid),
      .code      (codes.damping)
   );

   mcp_lane #(.CODE_BITS(mcp_pkg::NARROW_CODE_W)) u_trq_lane (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .x         (req_data.feedforward_torque),
      .lo        (trq_lo),
      .hi        (trq_hi),
      .valid_out (trq_valid),
      .code      (codes.torque)
   );

   mcp_frame_pack u_frame_pack (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (pos_valid),
      .codes      (codes),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`include "mit_motor_command_packer_assert.svh"

   `MCP_ASSERT_ALWAYS(a_lanes_aligned, pos_valid == vel_valid && pos_valid == kp_valid && pos_valid == kd_valid && pos_valid == trq_valid, "lanes out of step")
   `MCP_ASSERT_IMPL(a_strobe_has_request, rsp_strobe, $past(req_start && !busy, mcp_pkg::LATENCY), "frame without request")

endmodule

// File: test/mit_motor_command_packer_tb.sv
// testbench for the motor command packer: predicted frames checked against every response
module mit_motor_command_packer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REG_W         = mcp_pkg::REG_W;
   localparam int CSR_INDEX_W   = mcp_pkg::CSR_INDEX_W;
   localparam int SETPOINT_W    = mcp_pkg::SETPOINT_W;
   localparam int POS_CODE_W    = mcp_pkg::POS_CODE_W;
   localparam int NARROW_CODE_W = mcp_pkg::NARROW_CODE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_INDEX_UNUSED = 3'd7;
   localparam logic [REG_W-1:0]       REG_ALL_ONES     = {REG_W{1'b1}};
   localparam longint SETPOINT_MAX = 64'sd2147483647;
   localparam longint SETPOINT_MIN = -64'sd2147483648;
   localparam int NUM_RANGE_REGS   = 7;
   localparam int STALL_LIMIT      = 2000;
   localparam int REPORT_LIMIT     = 100;
   localparam int SETTINGS_PER_PHASE = 5;
   localparam int SETS_PER_SETTING   = 95;

   logic                   clock;
   logic                   reset;
   logic                   req_start;
   logic                   busy;
   mcp_pkg::mcp_req_type   req_data;
   logic                   rsp_strobe;
   mcp_pkg::mcp_rsp_type   rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [REG_W-1:0]       csr_data;

   logic [REG_W-1:0]     range_reg [0:NUM_RANGE_REGS-1];
   mcp_pkg::mcp_rsp_type expected_frames [$];
   int                   sender_idle_pct;
   int                   sets_sent;
   int                   frames_checked;
   int                   settings_applied;
   int                   failures;
   int                   reports;
   int                   stall_cycles;

   mit_motor_command_packer u_top (
      .clock        (clock),
      .reset        (reset),
      .req_start    (req_start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [POS_CODE_W-1:0] quantise_setpoint(
      logic signed [SETPOINT_W-1:0] x, longint lo, longint hi, int bits);
      longint full;
      longint xv;
      full = (longint'(1) << bits) - 1;
      xv   = x;
      if (hi <= lo) begin
         return '0;
      end
      if (xv < lo) begin
         xv = lo;
      end
      if (xv > hi) begin
         xv = hi;
      end
      return POS_CODE_W'(((xv - lo) * full) / (hi - lo));
   endfunction

   function automatic mcp_pkg::mcp_rsp_type pack_frame(mcp_pkg::mcp_req_type s);
      mcp_pkg::mcp_codes_type codes;
      longint pl;
      longint vl;
      longint tl;
      pl = range_reg[mcp_pkg::REG_POSITION_LIMIT];
      vl = range_reg[mcp_pkg::REG_VELOCITY_LIMIT];
      tl = range_reg[mcp_pkg::REG_TORQUE_LIMIT];
      codes.position  = quantise_setpoint(s.target_position, -pl, pl, POS_CODE_W);
      codes.velocity  = NARROW_CODE_W'(quantise_setpoint(s.target_velocity, -vl, vl,
                                                         NARROW_CODE_W));
      codes.stiffness = NARROW_CODE_W'(quantise_setpoint(s.stiffness_gain,
                                          range_reg[mcp_pkg::REG_STIFFNESS_MIN],
                                          range_reg[mcp_pkg::REG_STIFFNESS_MAX],
                                          NARROW_CODE_W));
      codes.damping   = NARROW_CODE_W'(quantise_setpoint(s.damping_gain,
                                          range_reg[mcp_pkg::REG_DAMPING_MIN],
                                          range_reg[mcp_pkg::REG_DAMPING_MAX],
                                          NARROW_CODE_W));
      codes.torque    = NARROW_CODE_W'(quantise_setpoint(s.feedforward_torque, -tl, tl,
                                                         NARROW_CODE_W));
      return mcp_pkg::mcp_rsp_type'(codes);
   endfunction

   function automatic logic signed [SETPOINT_W-1:0] to_setpoint(longint v);
      if (v > SETPOINT_MAX) begin
         v = SETPOINT_MAX;
      end else if (v < SETPOINT_MIN) begin
         v = SETPOINT_MIN;
      end
      return SETPOINT_W'(v);
   endfunction

   // mostly inside the range, with its ends, just beyond it and raw words
   function automatic logic signed [SETPOINT_W-1:0] pick_setpoint(longint lo, longint hi);
      longint v;
      case ($urandom_range(11))
         0, 1: begin
            v = longint'($signed($urandom()));
         end
         2: begin
            v = lo;
         end
         3: begin
            v = hi;
         end
         4: begin
            v = lo - 1 - longint'($urandom_range(1000));
         end
         5: begin
            v = hi + 1 + longint'($urandom_range(1000));
         end
         default: begin
            if (hi > lo) begin
               v = lo + longint'($urandom_range(32'(hi - lo)));
            end else begin
               v = lo + longint'($urandom_range(16)) - 8;
            end
         end
      endcase
      return to_setpoint(v);
   endfunction

   function automatic mcp_pkg::mcp_req_type random_setpoints();
      mcp_pkg::mcp_req_type s;
      longint pl;
      longint vl;
      longint tl;
      pl = range_reg[mcp_pkg::REG_POSITION_LIMIT];
      vl = range_reg[mcp_pkg::REG_VELOCITY_LIMIT];
      tl = range_reg[mcp_pkg::REG_TORQUE_LIMIT];
      s.target_position    = pick_setpoint(-pl, pl);
      s.target_velocity    = pick_setpoint(-vl, vl);
      s.stiffness_gain     = pick_setpoint(range_reg[mcp_pkg::REG_STIFFNESS_MIN],
                                           range_reg[mcp_pkg::REG_STIFFNESS_MAX]);
      s.damping_gain       = pick_setpoint(range_reg[mcp_pkg::REG_DAMPING_MIN],
                                           range_reg[mcp_pkg::REG_DAMPING_MAX]);
      s.feedforward_torque = pick_setpoint(-tl, tl);
      return s;
   endfunction

   // spread over all magnitudes, zero included
   function automatic logic [REG_W-1:0] random_reg_value();
      return REG_W'($urandom() >> $urandom_range(32, 2));
   endfunction

   task automatic send_setpoints(input mcp_pkg::mcp_req_type s);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_start = 1'b0;
         @(negedge clock);
      end
      req_start = 1'b1;
      req_data  = s;
      do begin
         @(posedge clock);
      end while (busy);
      expected_frames.push_back(pack_frame(s));
      sets_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_start = 1'b0;
      while (expected_frames.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_range_reg(input logic [CSR_INDEX_W-1:0] index,
                                  input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_data     = value;
      @(posedge clock);
      if (index <= mcp_pkg::REG_DAMPING_MAX) begin
         range_reg[index] = value;
      end
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic load_ranges(input logic [REG_W-1:0] pos_limit, input logic [REG_W-1:0] vel_limit,
                              input logic [REG_W-1:0] trq_limit,
                              input logic [REG_W-1:0] kp_min, input logic [REG_W-1:0] kp_max,
                              input logic [REG_W-1:0] kd_min, input logic [REG_W-1:0] kd_max);
      wait_drained();
      write_range_reg(mcp_pkg::REG_POSITION_LIMIT, pos_limit);
      write_range_reg(mcp_pkg::REG_VELOCITY_LIMIT, vel_limit);
      write_range_reg(mcp_pkg::REG_TORQUE_LIMIT, trq_limit);
      write_range_reg(mcp_pkg::REG_STIFFNESS_MIN, kp_min);
      write_range_reg(mcp_pkg::REG_STIFFNESS_MAX, kp_max);
      write_range_reg(mcp_pkg::REG_DAMPING_MIN, kd_min);
      write_range_reg(mcp_pkg::REG_DAMPING_MAX, kd_max);
      settings_applied++;
   endtask

   // zero, both word extremes, then for each setpoint one exact range end and one value past a range end
   task automatic send_range_corners();
      mcp_pkg::mcp_req_type s;
      longint pl;
      longint vl;
      longint tl;
      pl = range_reg[mcp_pkg::REG_POSITION_LIMIT];
      vl = range_reg[mcp_pkg::REG_VELOCITY_LIMIT];
      tl = range_reg[mcp_pkg::REG_TORQUE_LIMIT];
      send_setpoints('0);
      send_setpoints({5{32'h8000_0000}});
      send_setpoints({5{32'h7fff_ffff}});
      s.target_position    = to_setpoint(pl);
      s.target_velocity    = to_setpoint(-vl);
      s.stiffness_gain     = to_setpoint(range_reg[mcp_pkg::REG_STIFFNESS_MIN]);
      s.damping_gain       = to_setpoint(range_reg[mcp_pkg::REG_DAMPING_MAX]);
      s.feedforward_torque = to_setpoint(-tl);
      send_setpoints(s);
      s.target_position    = to_setpoint(-pl - 1);
      s.target_velocity    = to_setpoint(vl + 1);
      s.stiffness_gain     = to_setpoint(longint'(range_reg[mcp_pkg::REG_STIFFNESS_MIN]) - 1);
      s.damping_gain       = to_setpoint(longint'(range_reg[mcp_pkg::REG_DAMPING_MAX]) + 1);
      s.feedforward_torque = to_setpoint(tl + 1);
      send_setpoints(s);
   endtask

   task automatic test_reset_ranges();
      send_range_corners();
   endtask

   task automatic test_unused_index();
      wait_drained();
      write_range_reg(REG_INDEX_UNUSED, REG_ALL_ONES);
      send_range_corners();
   endtask

   task automatic test_range_extremes();
      load_ranges(REG_W'(1), REG_W'(1), REG_W'(1), '0, REG_W'(1), '0, REG_W'(1));
      send_range_corners();
      load_ranges(REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, '0, REG_ALL_ONES, '0, REG_ALL_ONES);
      send_range_corners();
      // zero limits, equal bounds and crossed bounds all give empty ranges
      load_ranges('0, '0, '0, REG_W'(5), REG_W'(5), REG_ALL_ONES, '0);
      send_range_corners();
   endtask

   task automatic test_random_traffic(input int idle_pct);
      logic [REG_W-1:0] kp_min;
      logic [REG_W-1:0] kd_min;
      logic [REG_W-1:0] kp_max;
      logic [REG_W-1:0] kd_max;
      logic [REG_W:0]   sum;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < SETTINGS_PER_PHASE; n++) begin
         kp_min = random_reg_value();
         kd_min = random_reg_value();
         sum    = kp_min + random_reg_value();
         kp_max = sum[REG_W] ? REG_ALL_ONES : sum[REG_W-1:0];
         sum    = kd_min + random_reg_value();
         kd_max = sum[REG_W] ? REG_ALL_ONES : sum[REG_W-1:0];
         if ($urandom_range(3) == 0) begin
            kp_max = random_reg_value();
            kd_max = random_reg_value();
         end
         load_ranges(random_reg_value(), random_reg_value(), random_reg_value(),
                     kp_min, kp_max, kd_min, kd_max);
         if ($urandom_range(3) == 0) begin
            write_range_reg(REG_INDEX_UNUSED, REG_W'($urandom()));
         end
         for (int i = 0; i < SETS_PER_SETTING; i++) begin
            send_setpoints(random_setpoints());
         end
      end
   endtask

   always @(posedge clock) begin
      mcp_pkg::mcp_rsp_type exp_frame;
      logic [63:0] e;
      logic [63:0] a;
      if (!reset && rsp_strobe) begin
         if (expected_frames.size() == 0) begin
            failures++;
            if (reports < REPORT_LIMIT) begin
               $display("%0t: frame with none expected, expected none actual %h",
                        $time, rsp_data);
               reports++;
            end
         end else begin
            exp_frame = expected_frames.pop_front();
            e = exp_frame;
            a = rsp_data;
            for (int b = 0; b < 8; b++) begin
               if (e[63-8*b -: 8] !== a[63-8*b -: 8]) begin
                  failures++;
                  if (reports < REPORT_LIMIT) begin
                     $display("%0t: frame %0d byte%0d expected %02h actual %02h",
                              $time, frames_checked, b, e[63-8*b -: 8], a[63-8*b -: 8]);
                     reports++;
                  end
               end
            end
            frames_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_start        = 1'b0;
      req_data         = '0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      sender_idle_pct  = 0;
      sets_sent        = 0;
      frames_checked   = 0;
      settings_applied = 1;
      failures         = 0;
      reports          = 0;
      stall_cycles     = 0;
      range_reg[mcp_pkg::REG_POSITION_LIMIT] = mcp_pkg::POSITION_LIMIT_RESET;
      range_reg[mcp_pkg::REG_VELOCITY_LIMIT] = mcp_pkg::VELOCITY_LIMIT_RESET;
      range_reg[mcp_pkg::REG_TORQUE_LIMIT]   = mcp_pkg::TORQUE_LIMIT_RESET;
      range_reg[mcp_pkg::REG_STIFFNESS_MIN]  = mcp_pkg::STIFFNESS_MIN_RESET;
      range_reg[mcp_pkg::REG_STIFFNESS_MAX]  = mcp_pkg::STIFFNESS_MAX_RESET;
      range_reg[mcp_pkg::REG_DAMPING_MIN]    = mcp_pkg::DAMPING_MIN_RESET;
      range_reg[mcp_pkg::REG_DAMPING_MAX]    = mcp_pkg::DAMPING_MAX_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_ranges();
      test_unused_index();
      test_range_extremes();
      test_random_traffic(19);
      test_random_traffic(77);
      test_random_traffic(0);

      wait_drained();
      repeat (mcp_pkg::LATENCY + 4) @(posedge clock);
      $display("%0d setpoint sets over %0d range settings, idle and back-to-back transfers",
               sets_sent, settings_applied);
      $display("%0d frames compared, %0d byte mismatches", frames_checked, failures);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
